### design/cas_pkg.sv
`timescale 1ns / 1ps
package cas_pkg;

  localparam int MAX_WAYS_DEF   = 8;
  localparam int MAX_SETS_DEF   = 256;
  localparam int COUNT_BITS_DEF = 16;

  localparam int TAG_W  = 32;
  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_REPL   = 3'd0;
  localparam logic [2:0] REG_WMODE  = 3'd1;
  localparam logic [2:0] REG_OFFSET = 3'd2;
  localparam logic [2:0] REG_INDEX  = 3'd3;
  localparam logic [2:0] REG_WAYS   = 3'd4;

  typedef enum logic {ST_IDLE, ST_LOOKUP} st_t;

  typedef struct packed {
    logic       repl_lfu;
    logic       write_thru;
    logic [3:0] offset_bits;
    logic [3:0] index_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

  typedef struct packed {
    logic       hit;
    logic       miss;
    logic [2:0] way;
    logic       write_back;
    logic [1:0] traffic;
  } res_t;

endpackage

### design/cas_cfg.sv
`timescale 1ns / 1ps
module cas_cfg
  import cas_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg
);

  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repl_lfu    <= 1'b0;
      cfg.write_thru  <= 1'b0;
      cfg.offset_bits <= 4'd4;
      cfg.index_bits  <= 4'd8;
      cfg.ways_in_use <= 4'd8;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_REPL:   cfg.repl_lfu    <= pwdata[0];
        REG_WMODE:  cfg.write_thru  <= pwdata[0];
        REG_OFFSET: cfg.offset_bits <= pwdata[3:0];
        REG_INDEX:  cfg.index_bits  <= pwdata[3:0];
        REG_WAYS:   cfg.ways_in_use <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_REPL:   prdata = {31'd0, cfg.repl_lfu};
      REG_WMODE:  prdata = {31'd0, cfg.write_thru};
      REG_OFFSET: prdata = {28'd0, cfg.offset_bits};
      REG_INDEX:  prdata = {28'd0, cfg.index_bits};
      REG_WAYS:   prdata = {28'd0, cfg.ways_in_use};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

### design/cas_mem.sv
`timescale 1ns / 1ps
module cas_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 400,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  // A row never written reads as all zero through its valid flag.
  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;
  logic [WIDTH-1:0] rd_raw;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= row_valid[rd_addr];
      end
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

### design/cas_policy.sv
`timescale 1ns / 1ps
module cas_policy
  import cas_pkg::*;
#(
  parameter int MAX_WAYS   = MAX_WAYS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int LINE_W     = 2 + TAG_W + COUNT_BITS,
  parameter int ROW_W      = MAX_WAYS * LINE_W + COUNT_BITS
) (
  input  cfg_t               cfg,
  input  logic               is_write,
  input  logic [TAG_W-1:0]   tag,
  input  logic [ROW_W-1:0]   row_in,
  output logic [ROW_W-1:0]   row_out,
  output res_t               res
);

  localparam int WW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NWW = $clog2(MAX_WAYS + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == CMAX) ? CMAX : v + 1'b1;
  endfunction

  logic                  vld [MAX_WAYS];
  logic                  drt [MAX_WAYS];
  logic [TAG_W-1:0]      tg  [MAX_WAYS];
  logic [COUNT_BITS-1:0] cnt [MAX_WAYS];
  logic [COUNT_BITS-1:0] cnt_n [MAX_WAYS];
  logic                  vld_n [MAX_WAYS];
  logic                  drt_n [MAX_WAYS];
  logic [TAG_W-1:0]      tg_n  [MAX_WAYS];
  logic [COUNT_BITS-1:0] set_age, set_age_n, best, age;
  logic [NWW-1:0]        nw;
  logic [WW-1:0]         hway, vway;
  logic                  hit, found, alloc, wb;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      vld[w] = row_in[w*LINE_W + LINE_W - 1];
      drt[w] = row_in[w*LINE_W + LINE_W - 2];
      tg[w]  = row_in[w*LINE_W + COUNT_BITS +: TAG_W];
      cnt[w] = row_in[w*LINE_W +: COUNT_BITS];
    end
    set_age = row_in[MAX_WAYS*LINE_W +: COUNT_BITS];

    if (cfg.ways_in_use == 4'd0) nw = NWW'(1);
    else if (32'(cfg.ways_in_use) > MAX_WAYS) nw = NWW'(MAX_WAYS);
    else nw = NWW'(cfg.ways_in_use);

    hit  = 1'b0;
    hway = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(nw) && vld[w] && tg[w] == tag) begin
        hit  = 1'b1;
        hway = WW'(w);
      end
    end

    found = 1'b0;
    vway  = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(nw) && !vld[w]) begin
        found = 1'b1;
        vway  = WW'(w);
      end
    end
    best = cnt[0];
    if (!found) begin
      for (int w = 1; w < MAX_WAYS; w++) begin
        if (w < int'(nw) && (cfg.repl_lfu ? (cnt[w] < best) : (cnt[w] > best))) begin
          best = cnt[w];
          vway = WW'(w);
        end
      end
    end

    for (int w = 0; w < MAX_WAYS; w++) begin
      cnt_n[w] = cnt[w];
      vld_n[w] = vld[w];
      drt_n[w] = drt[w];
      tg_n[w]  = tg[w];
    end
    set_age_n = set_age;
    age       = cnt[hway];
    alloc     = !hit && !(is_write && cfg.write_thru);
    wb        = 1'b0;
    res.traffic = 2'd0;

    if (hit) begin
      if (is_write) begin
        if (!cfg.write_thru) drt_n[hway] = 1'b1;
        else res.traffic = 2'd1;
      end
      if (cfg.repl_lfu) begin
        cnt_n[hway] = sat_inc(cnt[hway]);
      end else begin
        for (int w = 0; w < MAX_WAYS; w++) begin
          if (w < int'(nw) && cnt[w] < age) cnt_n[w] = sat_inc(cnt[w]);
        end
        cnt_n[hway] = '0;
      end
    end else begin
      res.traffic = 2'd1;
      if (alloc) begin
        if (cfg.repl_lfu) begin
          set_age_n   = cnt[vway];
          cnt_n[vway] = sat_inc(cnt[vway]);
        end else begin
          for (int w = 0; w < MAX_WAYS; w++) begin
            if (w < int'(nw)) cnt_n[w] = sat_inc(cnt[w]);
          end
          cnt_n[vway] = '0;
        end
        if (vld[vway] && drt[vway]) begin
          wb          = 1'b1;
          res.traffic = 2'd2;
        end
        tg_n[vway]  = tag;
        vld_n[vway] = 1'b1;
        drt_n[vway] = is_write && !cfg.write_thru;
      end
    end

    for (int w = 0; w < MAX_WAYS; w++) begin
      row_out[w*LINE_W +: LINE_W] = {vld_n[w], drt_n[w], tg_n[w], cnt_n[w]};
    end
    row_out[MAX_WAYS*LINE_W +: COUNT_BITS] = set_age_n;

    res.hit        = hit;
    res.miss       = !hit;
    res.write_back = wb;
    res.way        = hit ? 3'(hway) : (alloc ? 3'(vway) : 3'd0);
  end

endmodule

### design/set_assoc_cache_lru_lfu.sv
`timescale 1ns / 1ps
// Channel  Direction  Contents
// s_*      in         tuser: action; tdata: address
// m_*      out        tdata: hit, way, write_back, traffic_now, six statistics
// apb      in/out     registers at byte 0,4,8,12,16
// Each transaction reads the set row from the row memory in the accept cycle;
// the row is modified and written back when the lookup state completes, which
// waits on a full output register. The single port pair: items never overlap.
// Reset clears the row valid flags at once, so no clearing pass is needed.
// A stalled result holds the lookup until the output register is free.
module set_assoc_cache_lru_lfu
  import cas_pkg::*;
#(
  parameter int MAX_WAYS   = MAX_WAYS_DEF,
  parameter int MAX_SETS   = MAX_SETS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,   // address
  input  logic                s_tuser,   // action
  output logic                m_tvalid,
  input  logic                m_tready,
  // hit, way, write_back, traffic_now, reads_total, read_misses_total,
  // writes_total, write_misses_total, writebacks_total, traffic_total, pad
  output logic [199:0]        m_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int SW      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int IDX_LIM = $clog2(MAX_SETS + 1) - 1;
  localparam int LINE_W  = 2 + TAG_W + COUNT_BITS;
  localparam int ROW_W   = MAX_WAYS * LINE_W + COUNT_BITS;

  cfg_t             cfg;
  st_t              state, state_next;
  res_t             res;
  logic             accept, go;
  logic [3:0]       ib;
  logic [31:0]      set_full, tag_in;
  logic [SW-1:0]    set_q;
  logic [TAG_W-1:0] tag_q;
  logic             isw_q;
  logic [ROW_W-1:0] row_rd, row_wr;
  logic [31:0]      st_rd, st_rm, st_wr, st_wm, st_wb, st_tr;
  logic [31:0]      st_rd_next, st_rm_next, st_wr_next, st_wm_next, st_wb_next, st_tr_next;

  cas_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  always_comb begin
    ib       = (32'(cfg.index_bits) > IDX_LIM) ? 4'(IDX_LIM) : cfg.index_bits;
    set_full = (s_tdata >> cfg.offset_bits) & ((32'd1 << ib) - 32'd1);
    tag_in   = s_tdata >> (5'(cfg.offset_bits) + 5'(ib));
  end

  assign accept = s_tvalid && s_tready;

  cas_mem #(.DEPTH(MAX_SETS), .WIDTH(ROW_W), .AW(SW)) u_mem (
    .clk, .rst,
    .rd_en   (accept),
    .rd_addr (set_full[SW-1:0]),
    .rd_data (row_rd),
    .wr_en   (go),
    .wr_addr (set_q),
    .wr_data (row_wr)
  );

  cas_policy #(.MAX_WAYS(MAX_WAYS), .COUNT_BITS(COUNT_BITS)) u_policy (
    .cfg, .is_write(isw_q), .tag(tag_q), .row_in(row_rd), .row_out(row_wr), .res
  );

  always_comb begin
    case (state)
      ST_IDLE:   state_next = accept ? ST_LOOKUP : ST_IDLE;
      ST_LOOKUP: state_next = go ? ST_IDLE : ST_LOOKUP;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    go       = (state == ST_LOOKUP) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q <= set_full[SW-1:0];
      tag_q <= tag_in;
      isw_q <= s_tuser;
    end
  end

  always_comb begin
    st_rd_next = st_rd + {31'd0, !isw_q};
    st_wr_next = st_wr + {31'd0, isw_q};
    st_rm_next = st_rm + {31'd0, !isw_q && res.miss};
    st_wm_next = st_wm + {31'd0, isw_q && res.miss};
    st_wb_next = st_wb + {31'd0, res.write_back};
    st_tr_next = st_tr + {30'd0, res.traffic};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_rd <= '0; st_rm <= '0; st_wr <= '0;
      st_wm <= '0; st_wb <= '0; st_tr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (go) begin
        st_rd <= st_rd_next; st_rm <= st_rm_next; st_wr <= st_wr_next;
        st_wm <= st_wm_next; st_wb <= st_wb_next; st_tr <= st_tr_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= {1'b0, st_tr_next, st_wb_next, st_wm_next, st_wr_next, st_rm_next,
                  st_rd_next, res.traffic, res.write_back, res.way, res.hit};
    end
  end

  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_LOOKUP) else $error("accept did not start a lookup");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP && m_tvalid && !m_tready) |=> state == ST_LOOKUP)
    else $error("lookup finished into a full output register");

  a_traffic: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:5] != 2'b11 && !(m_tdata[0] && m_tdata[4])))
    else $error("inconsistent result flags");

endmodule

### dv/cas_checker.sv
`timescale 1ns / 1ps
module cas_checker
  import cas_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [31:0]         s_tdata,
  input  logic                s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [199:0]        m_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output int                  errors,
  output int                  pending,
  output int                  hits_seen,
  output int                  wbs_seen
);

  localparam int NSETS = MAX_SETS_DEF;
  localparam int NWAYS = MAX_WAYS_DEF;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [31:0] traffic_total;
    logic [31:0] writebacks_total;
    logic [31:0] write_misses_total;
    logic [31:0] writes_total;
    logic [31:0] read_misses_total;
    logic [31:0] reads_total;
    logic [1:0]  traffic_now;
    logic        write_back;
    logic [2:0]  way;
    logic        hit;
  } access_res_t;

  cfg_t        cfg;
  logic [31:0] tags    [NSETS*NWAYS];
  logic        valid   [NSETS*NWAYS];
  logic        dirty   [NSETS*NWAYS];
  logic [15:0] counts  [NSETS*NWAYS];
  logic [15:0] set_age [NSETS];
  logic [31:0] stats   [6];
  access_res_t expected_q[$];

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic access_res_t cache_access(logic is_wr, logic [31:0] addr);
    access_res_t r;
    int ib, nw, set_i, base, line, w;
    logic [31:0] tag;
    logic [15:0] age, best;
    logic found, hit_f, wb;
    int way;
    ib = (cfg.index_bits > 8) ? 8 : cfg.index_bits;
    nw = (cfg.ways_in_use == 0) ? 1 : (cfg.ways_in_use > NWAYS) ? NWAYS : cfg.ways_in_use;
    set_i = (addr >> cfg.offset_bits) & ((1 << ib) - 1);
    tag = addr >> (cfg.offset_bits + ib);
    base = set_i * NWAYS;
    hit_f = 0; wb = 0; way = 0;
    r = '0;
    if (is_wr) stats[2]++; else stats[0]++;
    for (w = 0; w < nw; w++) begin
      if (!hit_f && valid[base+w] && tags[base+w] == tag) begin
        hit_f = 1; way = w;
      end
    end
    if (hit_f) begin
      line = base + way;
      if (is_wr) begin
        if (!cfg.write_thru) dirty[line] = 1;
        else r.traffic_now = 1;
      end
      if (cfg.repl_lfu) begin
        counts[line] = sat_inc(counts[line]);
      end else begin
        age = counts[line];
        for (w = 0; w < nw; w++)
          if (counts[base+w] < age) counts[base+w] = sat_inc(counts[base+w]);
        counts[line] = 0;
      end
    end else begin
      if (is_wr) stats[3]++; else stats[1]++;
      r.traffic_now = 1;
      if (!(is_wr && cfg.write_thru)) begin
        found = 0;
        for (w = 0; w < nw; w++)
          if (!found && !valid[base+w]) begin way = w; found = 1; end
        if (!found) begin
          best = counts[base];
          way = 0;
          for (w = 1; w < nw; w++)
            if (cfg.repl_lfu ? (counts[base+w] < best) : (counts[base+w] > best)) begin
              best = counts[base+w]; way = w;
            end
        end
        line = base + way;
        if (cfg.repl_lfu) begin
          set_age[set_i] = counts[line];
          counts[line] = sat_inc(set_age[set_i]);
        end else begin
          for (w = 0; w < nw; w++) counts[base+w] = sat_inc(counts[base+w]);
          counts[line] = 0;
        end
        if (valid[line] && dirty[line]) begin
          wb = 1;
          r.traffic_now = r.traffic_now + 1;
          stats[4]++;
        end
        tags[line] = tag;
        valid[line] = 1;
        dirty[line] = is_wr && !cfg.write_thru;
      end
    end
    stats[5] += r.traffic_now;
    r.hit = hit_f;
    r.way = way[2:0];
    r.write_back = wb;
    r.reads_total = stats[0];
    r.read_misses_total = stats[1];
    r.writes_total = stats[2];
    r.write_misses_total = stats[3];
    r.writebacks_total = stats[4];
    r.traffic_total = stats[5];
    return r;
  endfunction

  task automatic report(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    access_res_t e, a;
    if (rst) begin
      cfg <= '{repl_lfu: 1'b0, write_thru: 1'b0, offset_bits: 4'd4,
               index_bits: 4'd8, ways_in_use: 4'd8};
      for (int i = 0; i < NSETS*NWAYS; i++) begin
        tags[i] = '0; valid[i] = 0; dirty[i] = 0; counts[i] = '0;
      end
      for (int i = 0; i < NSETS; i++) set_age[i] = '0;
      for (int i = 0; i < 6; i++) stats[i] = '0;
      expected_q.delete();
      errors = 0; hits_seen = 0; wbs_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_REPL:   cfg.repl_lfu <= pwdata[0];
          REG_WMODE:  cfg.write_thru <= pwdata[0];
          REG_OFFSET: cfg.offset_bits <= pwdata[3:0];
          REG_INDEX:  cfg.index_bits <= pwdata[3:0];
          REG_WAYS:   cfg.ways_in_use <= pwdata[3:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_q.push_back(cache_access(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        a = m_tdata[198:0];
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, a);
        end else begin
          e = expected_q.pop_front();
          hits_seen += a.hit;
          wbs_seen += a.write_back;
          report("hit", e.hit, a.hit);
          report("way", e.way, a.way);
          report("write_back", e.write_back, a.write_back);
          report("traffic_now", e.traffic_now, a.traffic_now);
          report("reads_total", e.reads_total, a.reads_total);
          report("read_misses_total", e.read_misses_total, a.read_misses_total);
          report("writes_total", e.writes_total, a.writes_total);
          report("write_misses_total", e.write_misses_total, a.write_misses_total);
          report("writebacks_total", e.writebacks_total, a.writebacks_total);
          report("traffic_total", e.traffic_total, a.traffic_total);
        end
      end
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import cas_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               s_tvalid = 0;
  logic               s_tready;
  logic [31:0]        s_tdata = '0;   // address
  logic               s_tuser = 0;    // action
  logic               m_tvalid;
  logic               m_tready = 0;
  logic [199:0]       m_tdata;        // hit, way, write_back, traffic_now, six totals, pad
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int   errors, pending, hits_seen, wbs_seen;
  bit   no_idle = 0;
  int   hold_req = 0;
  int   sent = 0;
  int   cur_ob = 4, cur_ib = 8;
  int   quiet = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  set_assoc_cache_lru_lfu u_top (.*);

  cas_checker u_chk (.*);

  task automatic apb_write(logic [2:0] reg_idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {reg_idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic configure(bit lfu, bit wt, int ob, int ib, int ways);
    apb_write(REG_REPL, 32'(lfu));
    apb_write(REG_WMODE, 32'(wt));
    apb_write(REG_OFFSET, 32'(ob));
    apb_write(REG_INDEX, 32'(ib));
    apb_write(REG_WAYS, 32'(ways));
    cur_ob = ob;
    cur_ib = (ib > 8) ? 8 : ib;
  endtask

  task automatic send(bit wr, logic [31:0] addr);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 25) begin
        s_tvalid <= 0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1; s_tuser <= wr; s_tdata <= addr;
    do @(posedge clk); while (!s_tready);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    int sh;
    sh = cur_ob + cur_ib;
    if ($urandom_range(0, 99) < 20) return $urandom;
    a = $urandom_range(0, 11);
    a = (a << sh) | ($urandom_range(0, 3) << cur_ob) | ($urandom & ((1 << cur_ob) - 1));
    return a;
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) no_idle = 1;
      if (i == n / 3 + 40) no_idle = 0;
      if (i == n / 2 && hold_req == 0) hold_req++;
      send(1'($urandom_range(0, 1)), pick_addr());
    end
  endtask

  always begin
    int seen, hold_cnt;
    seen = 0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        m_tready <= 0;
        hold_cnt--;
      end else begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 2000) begin
      $display("set_assoc_cache_lru_lfu test failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 0;
    for (int t = 0; t < 9; t++) send(1, (t << 12) | 32'h35);
    send(0, 32'h0000_0030);
    send(0, (8 << 12) | 32'h30);
    send(1, (8 << 12) | 32'h3F);
    send(0, 32'h0000_0000);
    send(1, 32'hFFFF_FFFF);
    send(0, 32'hFFFF_FFF0);
    send(0, 32'h8000_0000);
    drain();
    random_run(200);
    drain();
    configure(1, 0, 0, 0, 1);
    random_run(140);
    drain();
    configure(0, 1, 12, 8, 8);
    random_run(140);
    drain();
    configure(1, 1, 4, 2, 4);
    random_run(140);
    drain();
    configure(0, 0, 5, 15, 0);
    random_run(140);
    drain();
    configure(1, 0, 3, 3, 15);
    random_run(140);
    drain();
    configure(0, 1, 2, 1, 2);
    random_run(140);
    drain();
    repeat (20) @(negedge clk);
    $display("Ran %0d accesses over seven register settings in both replacement modes.",
             sent);
    $display("Results showed %0d hits and %0d dirty writebacks.", hits_seen, wbs_seen);
    if (errors == 0) begin
      $display("set_assoc_cache_lru_lfu test passed");
    end else begin
      $display("set_assoc_cache_lru_lfu test failed");
    end
    $finish;
  end

endmodule
